// File: hw/rtl/agsm_pkg.sv
// Shared types and constants for the automatic gear shift manager.
// No dependencies; every other file imports this package.
`default_nettype none

package agsm_pkg;

  // Input action codes
  localparam logic [1:0] ACT_REPORT  = 2'd0;
  localparam logic [1:0] ACT_LOAD    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Shift status codes from the transmission
  localparam logic [2:0] STAT_UNINIT = 3'd0;
  localparam logic [2:0] STAT_AVAIL  = 3'd1;
  localparam logic [2:0] STAT_LOCKED = 3'd2;
  localparam logic [2:0] STAT_UP     = 3'd3;
  localparam logic [2:0] STAT_DOWN   = 3'd4;

  // Event codes reported with each result
  localparam logic [3:0] EV_NONE       = 4'd0;
  localparam logic [3:0] EV_BAD_STATUS = 4'd1;
  localparam logic [3:0] EV_ENGINE_OFF = 4'd2;
  localparam logic [3:0] EV_WAITING    = 4'd3;
  localparam logic [3:0] EV_STILL      = 4'd4;
  localparam logic [3:0] EV_LOCKED     = 4'd5;
  localparam logic [3:0] EV_SUCCESS    = 4'd6;
  localparam logic [3:0] EV_FAILED     = 4'd7;
  localparam logic [3:0] EV_RESYNC     = 4'd8;
  localparam logic [3:0] EV_DOWN       = 4'd9;
  localparam logic [3:0] EV_UP         = 4'd10;

  // Configuration register indexes
  localparam logic [1:0] REG_WAIT_MS    = 2'd0;
  localparam logic [1:0] REG_GEAR_COUNT = 2'd1;
  localparam logic [1:0] REG_START_GEAR = 2'd2;

  // Engine counts as stalled at or below this speed
  localparam logic [14:0] STALL_RPM = 15'd500;

  // Command queue between front and back (power of two)
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_NOP        = 3'd0,
    CMD_REPORT     = 3'd1,
    CMD_BAD_STATUS = 3'd2,
    CMD_LOAD       = 3'd3,
    CMD_RESTART    = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         idx;
    logic signed [7:0]  gear;
    logic [14:0]        min_rpm;
    logic [14:0]        max_rpm;
    logic [2:0]         status;
    logic [14:0]        rpm;
    logic               rpm_low;
    logic [31:0]        time_ms;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        wait_ms;
    logic [3:0]         gear_count;
    logic signed [7:0]  home_gear;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/agsm_front.sv
// Front end: accepts items, classifies them and queues commands for the back end.
// Depends on agsm_pkg.
`default_nettype none

module agsm_front import agsm_pkg::*; #(
  parameter int MAX_GEARS = 8
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  output logic               full,
  input  wire  [1:0]         action,
  input  wire  [2:0]         entry_index,
  input  wire  signed [7:0]  gear_num,
  input  wire  [14:0]        min_rpm,
  input  wire  [14:0]        max_rpm,
  input  wire  [2:0]         shift_status,
  input  wire  [14:0]        eng_rpm,
  input  wire  [31:0]        time_ms,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  wire                cmd_take
);

  cmd_t                   q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0]  wr_ptr;
  logic [CMDQ_PTR_W-1:0]  rd_ptr;
  logic [CMDQ_CNT_W-1:0]  count;
  cmd_t                   cls;
  logic                   push_ok;
  logic                   take_ok;

  // Classify the incoming item
  always_comb begin
    cls.idx     = entry_index;
    cls.gear    = gear_num;
    cls.min_rpm = min_rpm;
    cls.max_rpm = max_rpm;
    cls.status  = shift_status;
    cls.rpm     = eng_rpm;
    cls.rpm_low = (eng_rpm <= STALL_RPM);
    cls.time_ms = time_ms;
    unique case (action)
      ACT_REPORT:  cls.kind = (shift_status > STAT_DOWN) ? CMD_BAD_STATUS : CMD_REPORT;
      ACT_LOAD:    cls.kind = (5'(entry_index) < 5'(MAX_GEARS)) ? CMD_LOAD : CMD_NOP;
      ACT_RESTART: cls.kind = CMD_RESTART;
      default:     cls.kind = CMD_NOP;
    endcase
  end

  assign full      = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign push_ok   = push && !full;
  assign take_ok   = cmd_take && cmd_valid;

  // Write the classified item into the queue
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= cls;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_ok && !take_ok) begin
        count <= count + 1'b1;
      end else if (take_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CMDQ_CNT_W'(CMDQ_DEPTH))
    else $error("command queue count beyond depth");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> cmd_valid)
    else $error("accepted item did not reach the command queue");

endmodule

`default_nettype wire

// File: hw/rtl/agsm_back.sv
// Back end: walks the gear table for each engine report, updates the shift state and
// holds the result item in an output register. Depends on agsm_pkg.
`default_nettype none

module agsm_back import agsm_pkg::*; #(
  parameter int MAX_GEARS = 8
) (
  input  wire                clk,
  input  wire                rst,
  input  cfg_t               cfg,
  input  wire                cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_take,
  output logic               empty,
  input  wire                pop,
  output logic signed [7:0]  gear_cmd,
  output logic               waiting_for_shift,
  output logic [31:0]        last_shift_ms,
  output logic [3:0]         event_res
);

  localparam int IDX_W = (MAX_GEARS > 1) ? $clog2(MAX_GEARS) : 1;
  localparam int CNT_W = $clog2(MAX_GEARS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state;

  // Gear table, one entry per slot
  logic signed [7:0] tbl_num [MAX_GEARS];
  logic [14:0]       tbl_min [MAX_GEARS];
  logic [14:0]       tbl_max [MAX_GEARS];

  // Shift state
  logic signed [7:0] cur_gear, cur_gear_next;
  logic signed [7:0] phys_gear, phys_gear_next;
  logic signed [7:0] cmd_gear, cmd_gear_next;
  logic              pend, pend_next;
  logic [31:0]       last_time, last_time_next;

  // Command under work and walk results
  cmd_t              cur_cmd;
  logic [IDX_W-1:0]  walk_idx;
  logic              hit_in, hit_phys, hit_cur;
  logic [14:0]       cur_min, cur_max;
  logic              has_lower, has_higher;
  logic signed [7:0] lower_gear, higher_gear;

  // Result register
  logic              res_valid;
  logic [3:0]        ev;
  logic              tbl_we;
  logic              fin_go;
  logic [CNT_W-1:0]  n_cnt;
  logic              walk_last;
  logic signed [7:0] ent_num;
  logic [14:0]       ent_min, ent_max;
  logic signed [7:0] in_gear;
  logic signed [7:0] phys_new;
  logic              phys_known;
  logic [31:0]       elapsed;
  logic [4:0]        ld_idx;

  // Clamp the table size to the slots that exist
  assign n_cnt = ({1'b0, cfg.gear_count} > 5'(MAX_GEARS)) ? CNT_W'(MAX_GEARS)
                                                         : CNT_W'(cfg.gear_count);
  assign walk_last = ((CNT_W'(walk_idx) + 1'b1) == n_cnt);
  assign ent_num   = tbl_num[walk_idx];
  assign ent_min   = tbl_min[walk_idx];
  assign ent_max   = tbl_max[walk_idx];
  assign in_gear   = cur_cmd.gear;
  assign ld_idx    = 5'(cur_cmd.idx);

  assign cmd_take = (state == ST_IDLE) && cmd_valid;
  assign fin_go   = (state == ST_FIN) && (!res_valid || pop);
  assign empty    = !res_valid;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            state <= (cmd.kind == CMD_REPORT && n_cnt != '0) ? ST_WALK : ST_FIN;
          end
        end
        ST_WALK: begin
          if (walk_last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Latch the command and sweep the table one slot a cycle
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur_cmd    <= cmd;
      walk_idx   <= '0;
      hit_in     <= 1'b0;
      hit_phys   <= 1'b0;
      hit_cur    <= 1'b0;
      has_lower  <= 1'b0;
      has_higher <= 1'b0;
    end else if (state == ST_WALK) begin
      walk_idx <= walk_idx + 1'b1;
      if (ent_num == in_gear) begin
        hit_in <= 1'b1;
      end
      if (ent_num == phys_gear) begin
        hit_phys <= 1'b1;
      end
      if (!hit_cur && ent_num == cur_gear) begin
        hit_cur <= 1'b1;
        cur_min <= ent_min;
        cur_max <= ent_max;
      end
      // keep the last lower gear in table order
      if (ent_num < cur_gear) begin
        has_lower  <= 1'b1;
        lower_gear <= ent_num;
      end
      // keep the first higher gear in table order
      if (!has_higher && ent_num > cur_gear) begin
        has_higher  <= 1'b1;
        higher_gear <= ent_num;
      end
    end
  end

  assign phys_new   = hit_in ? in_gear : phys_gear;
  assign phys_known = hit_in || hit_phys;
  assign elapsed    = cur_cmd.time_ms - last_time;

  // Decide the outcome of the command
  always_comb begin
    cur_gear_next  = cur_gear;
    phys_gear_next = phys_gear;
    cmd_gear_next  = cmd_gear;
    pend_next      = pend;
    last_time_next = last_time;
    ev             = EV_NONE;
    tbl_we         = 1'b0;
    unique case (cur_cmd.kind)
      CMD_BAD_STATUS: ev = EV_BAD_STATUS;
      CMD_LOAD:       tbl_we = 1'b1;
      CMD_RESTART: begin
        cur_gear_next  = cfg.home_gear;
        cmd_gear_next  = cfg.home_gear;
        phys_gear_next = '0;
        pend_next      = 1'b0;
        last_time_next = '0;
      end
      CMD_REPORT: begin
        phys_gear_next = phys_new;
        priority if (cur_cmd.rpm_low) begin
          ev = EV_ENGINE_OFF;
        end else if (pend) begin
          priority if (elapsed < 32'(cfg.wait_ms)) begin
            ev = EV_WAITING;
          end else if (cur_cmd.status == STAT_UNINIT || cur_cmd.status == STAT_UP ||
                       cur_cmd.status == STAT_DOWN) begin
            last_time_next = cur_cmd.time_ms;
            ev             = EV_STILL;
          end else if (cur_cmd.status == STAT_LOCKED) begin
            last_time_next = cur_cmd.time_ms;
            ev             = EV_LOCKED;
          end else begin
            pend_next = 1'b0;
            if (phys_new != cur_gear) begin
              if (phys_known) begin
                cur_gear_next = phys_new;
              end
              ev = EV_SUCCESS;
            end else begin
              cmd_gear_next = phys_new;
              ev            = EV_FAILED;
            end
          end
        end else if (cur_cmd.status > STAT_LOCKED) begin
          ev = EV_NONE;
        end else if (cur_gear != phys_new) begin
          if (phys_known) begin
            cur_gear_next = phys_new;
          end
          ev = EV_RESYNC;
        end else if (!hit_cur) begin
          ev = EV_NONE;
        end else if (cur_cmd.rpm < cur_min && has_lower) begin
          cmd_gear_next  = lower_gear;
          last_time_next = cur_cmd.time_ms;
          pend_next      = 1'b1;
          ev             = EV_DOWN;
        end else if (cur_cmd.rpm > cur_max && has_higher) begin
          cmd_gear_next  = higher_gear;
          last_time_next = cur_cmd.time_ms;
          pend_next      = 1'b1;
          ev             = EV_UP;
        end else begin
          ev = EV_NONE;
        end
      end
      default: ev = EV_NONE;
    endcase
  end

  // Write a loaded table entry
  always_ff @(posedge clk) begin
    if (fin_go && tbl_we) begin
      tbl_num[ld_idx[IDX_W-1:0]] <= cur_cmd.gear;
      tbl_min[ld_idx[IDX_W-1:0]] <= cur_cmd.min_rpm;
      tbl_max[ld_idx[IDX_W-1:0]] <= cur_cmd.max_rpm;
    end
  end

  // Commit the shift state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_gear  <= '0;
      phys_gear <= '0;
      cmd_gear  <= '0;
      pend      <= 1'b0;
      last_time <= '0;
    end else if (fin_go) begin
      cur_gear  <= cur_gear_next;
      phys_gear <= phys_gear_next;
      cmd_gear  <= cmd_gear_next;
      pend      <= pend_next;
      last_time <= last_time_next;
    end
  end

  // Hold the result item until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_go) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      gear_cmd          <= cmd_gear_next;
      waiting_for_shift <= pend_next;
      last_shift_ms     <= last_time_next;
      event_res         <= ev;
    end
  end

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (CNT_W'(walk_idx) < n_cnt))
    else $error("table walk past the valid entries");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> (state == ST_WALK || state == ST_FIN))
    else $error("command taken without starting work");

  a_shift_pends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (event_res == EV_DOWN || event_res == EV_UP)) |-> waiting_for_shift)
    else $error("shift commanded without pending flag");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (event_res == EV_SUCCESS || event_res == EV_FAILED)) |-> !waiting_for_shift)
    else $error("finished shift still pending");

endmodule

`default_nettype wire

// File: hw/rtl/auto_gear_shift_manager_top.sv
// Top level of the automatic gear shift manager: configuration registers and
// the front and back ends. Depends on agsm_pkg, agsm_front, agsm_back.
//
//  channel   handshake          payload
//  --------  -----------------  -------------------------------------------------
//  input     push / full        action entry_index gear_num min_rpm max_rpm
//                               shift_status eng_rpm time_ms
//  result    empty / pop        gear_cmd waiting_for_shift last_shift_ms event_res
//  config    cfg_we             cfg_addr cfg_data (wait_ms, gear_count, home_gear)
//
// In the back end an engine report is picked up as a command, then walks each valid
// table slot (none when the table is empty), then commits the result. Load, restart
// and rejected items skip the walk. The table walk sets the rate.
// The front queue holds two items, so input stalls only when the back end lags.
// Reset (rst, synchronous) empties both queues and clears the shift state; the table
// holds whatever was last loaded.
`default_nettype none

module auto_gear_shift_manager_top import agsm_pkg::*; #(
  parameter int MAX_GEARS = 8
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  output logic               full,
  input  wire  [1:0]         action,
  input  wire  [2:0]         entry_index,
  input  wire  signed [7:0]  gear_num,
  input  wire  [14:0]        min_rpm,
  input  wire  [14:0]        max_rpm,
  input  wire  [2:0]         shift_status,
  input  wire  [14:0]        eng_rpm,
  input  wire  [31:0]        time_ms,
  output logic               empty,
  input  wire                pop,
  output logic signed [7:0]  gear_cmd,
  output logic               waiting_for_shift,
  output logic [31:0]        last_shift_ms,
  output logic [3:0]         event_res,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_addr,
  input  wire  [15:0]        cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_ms    <= 16'd500;
      cfg.gear_count <= 4'd1;
      cfg.home_gear  <= 8'sd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WAIT_MS:    cfg.wait_ms    <= cfg_data;
        REG_GEAR_COUNT: cfg.gear_count <= cfg_data[3:0];
        REG_START_GEAR: cfg.home_gear  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  agsm_front #(
    .MAX_GEARS (MAX_GEARS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .action       (action),
    .entry_index  (entry_index),
    .gear_num     (gear_num),
    .min_rpm      (min_rpm),
    .max_rpm      (max_rpm),
    .shift_status (shift_status),
    .eng_rpm      (eng_rpm),
    .time_ms      (time_ms),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  agsm_back #(
    .MAX_GEARS (MAX_GEARS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_take          (cmd_take),
    .empty             (empty),
    .pop               (pop),
    .gear_cmd          (gear_cmd),
    .waiting_for_shift (waiting_for_shift),
    .last_shift_ms     (last_shift_ms),
    .event_res         (event_res)
  );

endmodule

`default_nettype wire
